/* hdl/hlscc_pkg.sv */
// ----------------------------------------------------------------------------
// hlscc_pkg
// Shared constants, types and constant-divisor helpers for the RGB/HLS
// color converter.
// ----------------------------------------------------------------------------
`default_nettype none

package hlscc_pkg;

    // Color scales
    localparam int HLS_SCALE   = 360;
    localparam int RGB_TOP     = 255;
    localparam int RGB_SPAN    = 2 * RGB_TOP;
    localparam int HUE_NONE    = (HLS_SCALE * 2) / 3;
    localparam int HUE_THIRD   = HLS_SCALE / 3;
    localparam int HUE_SIXTH   = HLS_SCALE / 6;
    localparam int HUE_HALF    = HLS_SCALE / 2;
    localparam int HUE_TWELFTH = HLS_SCALE / 12;

    // Lightness numerator below this gives lightness <= HLS_SCALE/2
    localparam int LNUM_LOW_LIMIT = (HUE_HALF + 1) * RGB_SPAN;

    localparam logic [15:0] GAIN_RESET = 16'd256;

    // Channel and divider widths
    localparam int CHAN_W = 9;
    localparam int DIV_NW = 17;
    localparam int DIV_DW = 9;
    localparam int DIV_QW = 9;

    // Function selector codes
    typedef enum logic [1:0] {
        FN_RGB2HLS = 2'd0,
        FN_HLS2RGB = 2'd1,
        FN_SCALE   = 2'd2,
        FN_NONE    = 2'd3
    } t_func;

    // Request passed from the RGB-to-HLS front into the HLS-to-RGB back end
    typedef struct packed {
        t_func             func;
        logic [CHAN_W-1:0] h;
        logic [CHAN_W-1:0] l;
        logic [CHAN_W-1:0] s;
    } t_hls;

    // Reciprocal constants: exact floor division for numerators below 2**DIV_XW
    localparam int DIV_XW = 20;
    localparam int K_SPAN  = DIV_XW + $clog2(RGB_SPAN);
    localparam int K_SCALE = DIV_XW + $clog2(HLS_SCALE);
    localparam int K_SIXTH = DIV_XW + $clog2(HUE_SIXTH);
    localparam logic [63:0] M_SPAN =
        ((64'd1 << K_SPAN) + 64'(RGB_SPAN) - 64'd1) / 64'(RGB_SPAN);
    localparam logic [63:0] M_SCALE =
        ((64'd1 << K_SCALE) + 64'(HLS_SCALE) - 64'd1) / 64'(HLS_SCALE);
    localparam logic [63:0] M_SIXTH =
        ((64'd1 << K_SIXTH) + 64'(HUE_SIXTH) - 64'd1) / 64'(HUE_SIXTH);

    // Divide by twice the RGB top value
    function automatic logic [DIV_XW-1:0] div_span(input logic [DIV_XW-1:0] x);
        logic [63:0] p;
        p = 64'(x) * M_SPAN;
        return DIV_XW'(p >> K_SPAN);
    endfunction

    // Divide by the HLS scale
    function automatic logic [DIV_XW-1:0] div_scale(input logic [DIV_XW-1:0] x);
        logic [63:0] p;
        p = 64'(x) * M_SCALE;
        return DIV_XW'(p >> K_SCALE);
    endfunction

    // Divide by one sixth of the HLS scale
    function automatic logic [DIV_XW-1:0] div_sixth(input logic [DIV_XW-1:0] x);
        logic [63:0] p;
        p = 64'(x) * M_SIXTH;
        return DIV_XW'(p >> K_SIXTH);
    endfunction

endpackage

`default_nettype wire

/* hdl/rgb_hls_color_convert.sv */
// ----------------------------------------------------------------------------
// rgb_hls_color_convert
// Integer RGB <-> HLS color converter on the 0..360 HLS scale, with a
// lightness-gain mode that converts RGB to HLS, scales L and converts back.
//
//   channel   signals                                 direction
//   request   i_valid, o_stall, i_func, i_chan_*      in
//   result    o_valid, i_stall, o_res_*               out
//   config    i_cfg_we, i_cfg_wdata (lightness gain)  in
//
// One request is taken per clock while o_stall is low; the pipe has 4 front stages,
// a 9-stage bit-per-stage divider for saturation and hue, and 6 back stages.
// The whole pipeline advances together whenever the output register is
// empty or its result is taken, so a stalled result holds every stage.
// Reset is synchronous, active low, and clears the valid bits and the
// gain register (gain 1.0).
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_hls_color_convert
    import hlscc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [15:0]       i_cfg_wdata,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [1:0]        i_func,
    input  wire logic [CHAN_W-1:0] i_chan_first,
    input  wire logic [CHAN_W-1:0] i_chan_second,
    input  wire logic [CHAN_W-1:0] i_chan_third,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [CHAN_W-1:0]      o_res_first,
    output logic [CHAN_W-1:0]      o_res_second,
    output logic [CHAN_W-1:0]      o_res_third
);

    logic [15:0] r_gain;
    logic        adv;
    logic        fwd_valid;
    t_hls        fwd_hls;

    // Hold the lightness gain register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
        end else if (i_cfg_we) begin
            r_gain <= i_cfg_wdata;
        end
    end

    // Advance all stages when the output slot is free or being drained
    assign adv     = !o_valid || !i_stall;
    assign o_stall = !adv;

    hlscc_fwd u_fwd (
        .i_clk,
        .i_rst_n,
        .i_adv         (adv),
        .i_valid,
        .i_func,
        .i_chan_first,
        .i_chan_second,
        .i_chan_third,
        .i_gain        (r_gain),
        .o_valid       (fwd_valid),
        .o_hls         (fwd_hls)
    );

    hlscc_inv u_inv (
        .i_clk,
        .i_rst_n,
        .i_adv         (adv),
        .i_valid       (fwd_valid),
        .i_hls         (fwd_hls),
        .o_valid,
        .o_res_first,
        .o_res_second,
        .o_res_third
    );

endmodule

`default_nettype wire

/* hdl/hlscc_div.sv */
// ----------------------------------------------------------------------------
// hlscc_div
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module hlscc_div
    import hlscc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_adv,
    input  wire logic [DIV_NW-1:0] i_dividend,
    input  wire logic [DIV_DW-1:0] i_divisor,
    output logic      [DIV_QW-1:0] o_quot
);

    localparam int TW = DIV_NW + DIV_QW;

    logic [DIV_NW-1:0] r_rem [DIV_QW-1];
    logic [DIV_DW-1:0] r_dvs [DIV_QW-1];
    logic [DIV_QW-1:0] r_quo [DIV_QW];

    for (genvar k = 0; k < DIV_QW; k++) begin : g_step
        localparam int SH = DIV_QW - 1 - k;
        logic [DIV_NW-1:0] rem_in;
        logic [DIV_DW-1:0] dvs_in;
        logic [DIV_QW-1:0] quo_in;
        logic [TW-1:0]     trial;
        logic              take;

        if (k == 0) begin : g_first
            assign rem_in = i_dividend;
            assign dvs_in = i_divisor;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign dvs_in = r_dvs[k-1];
            assign quo_in = r_quo[k-1];
        end

        // Try the shifted divisor against the partial remainder
        assign trial = TW'(dvs_in) << SH;
        assign take  = TW'(rem_in) >= trial;

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_quo[k] <= quo_in | (DIV_QW'(take) << SH);
            end
        end

        if (k < DIV_QW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_rem[k] <= take ? (rem_in - trial[DIV_NW-1:0]) : rem_in;
                    r_dvs[k] <= dvs_in;
                end
            end
        end
    end

    assign o_quot = r_quo[DIV_QW-1];

endmodule

`default_nettype wire

/* hdl/hlscc_fwd.sv */
// ----------------------------------------------------------------------------
// hlscc_fwd
// RGB-to-HLS front end: clamp, extremes, lightness, divider pipeline for
// saturation and hue deltas, hue assembly and lightness gain.
// ----------------------------------------------------------------------------
`default_nettype none

module hlscc_fwd
    import hlscc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_adv,
    input  wire logic              i_valid,
    input  wire logic [1:0]        i_func,
    input  wire logic [CHAN_W-1:0] i_chan_first,
    input  wire logic [CHAN_W-1:0] i_chan_second,
    input  wire logic [CHAN_W-1:0] i_chan_third,
    input  wire logic [15:0]       i_gain,
    output logic                   o_valid,
    output t_hls                   o_hls
);

    typedef struct packed {
        t_func             func;
        logic [CHAN_W-1:0] c1;
        logic [CHAN_W-1:0] c2;
        logic [CHAN_W-1:0] c3;
        logic [CHAN_W-1:0] l;
        logic              rmax;
        logic              gmax;
        logic              achrom;
    } t_side;

    // ---------------- stage 1: clamp ----------------
    logic              r1_v;
    t_func             r1_func;
    logic [CHAN_W-1:0] r1_c1, r1_c2, r1_c3;
    logic [CHAN_W-1:0] n_top;

    assign n_top = (t_func'(i_func) == FN_HLS2RGB) ? CHAN_W'(HLS_SCALE) : CHAN_W'(RGB_TOP);

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_func <= t_func'(i_func);
            r1_c1   <= (i_chan_first  > n_top) ? n_top : i_chan_first;
            r1_c2   <= (i_chan_second > n_top) ? n_top : i_chan_second;
            r1_c3   <= (i_chan_third  > n_top) ? n_top : i_chan_third;
        end
    end

    // ---------------- stage 2: extremes and lightness numerator ----------------
    logic              r2_v;
    t_func             r2_func;
    logic [CHAN_W-1:0] r2_c1, r2_c2, r2_c3, r2_hi, r2_spread;
    logic [CHAN_W:0]   r2_sum;
    logic [19:0]       r2_lnum;
    logic              r2_rmax, r2_gmax;
    logic [CHAN_W-1:0] n_hi, n_lo;

    always_comb begin
        n_hi = (r1_c1 > r1_c2) ? r1_c1 : r1_c2;
        n_lo = (r1_c1 < r1_c2) ? r1_c1 : r1_c2;
        if (r1_c3 > n_hi) n_hi = r1_c3;
        if (r1_c3 < n_lo) n_lo = r1_c3;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r2_func   <= r1_func;
            r2_c1     <= r1_c1;
            r2_c2     <= r1_c2;
            r2_c3     <= r1_c3;
            r2_hi     <= n_hi;
            r2_spread <= n_hi - n_lo;
            r2_sum    <= (CHAN_W+1)'(n_hi) + (CHAN_W+1)'(n_lo);
            r2_lnum   <= 20'((20'(n_hi) + 20'(n_lo)) * 20'(HLS_SCALE)) + 20'(RGB_TOP);
            r2_rmax   <= (r1_c1 == n_hi);
            r2_gmax   <= (r1_c2 == n_hi);
        end
    end

    // ---------------- stage 3: lightness and divider operands ----------------
    logic              r3_v;
    t_side             r3_side;
    logic [DIV_NW-1:0] r3_s_dend, r3_r_dend, r3_g_dend, r3_b_dend;
    logic [DIV_DW-1:0] r3_s_dvs, r3_h_dvs;
    logic              n_lsmall;
    logic [CHAN_W:0]   n_sden;

    assign n_lsmall = r2_lnum < 20'(LNUM_LOW_LIMIT);
    assign n_sden   = n_lsmall ? r2_sum : ((CHAN_W+1)'(RGB_SPAN) - r2_sum);

    function automatic logic [DIV_NW-1:0] hue_dend(input logic [CHAN_W-1:0] hi,
                                                   input logic [CHAN_W-1:0] x,
                                                   input logic [CHAN_W-1:0] spread);
        return DIV_NW'(DIV_NW'(hi - x) * DIV_NW'(HUE_SIXTH)) + DIV_NW'(spread >> 1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r3_side.func   <= r2_func;
            r3_side.c1     <= r2_c1;
            r3_side.c2     <= r2_c2;
            r3_side.c3     <= r2_c3;
            r3_side.l      <= CHAN_W'(div_span(r2_lnum));
            r3_side.rmax   <= r2_rmax;
            r3_side.gmax   <= r2_gmax;
            r3_side.achrom <= (r2_spread == '0);
            r3_s_dend <= DIV_NW'(DIV_NW'(r2_spread) * DIV_NW'(HLS_SCALE))
                         + DIV_NW'(n_sden >> 1);
            r3_s_dvs  <= DIV_DW'(n_sden);
            r3_r_dend <= hue_dend(r2_hi, r2_c1, r2_spread);
            r3_g_dend <= hue_dend(r2_hi, r2_c2, r2_spread);
            r3_b_dend <= hue_dend(r2_hi, r2_c3, r2_spread);
            r3_h_dvs  <= r2_spread;
        end
    end

    // ---------------- dividers, side data delayed alongside ----------------
    logic [DIV_QW-1:0] n_sq, n_qr, n_qg, n_qb;
    t_side             r_side [DIV_QW];
    logic [DIV_QW-1:0] r_dv;

    hlscc_div u_div_s (.i_clk, .i_adv, .i_dividend(r3_s_dend), .i_divisor(r3_s_dvs),
                       .o_quot(n_sq));
    hlscc_div u_div_r (.i_clk, .i_adv, .i_dividend(r3_r_dend), .i_divisor(r3_h_dvs),
                       .o_quot(n_qr));
    hlscc_div u_div_g (.i_clk, .i_adv, .i_dividend(r3_g_dend), .i_divisor(r3_h_dvs),
                       .o_quot(n_qg));
    hlscc_div u_div_b (.i_clk, .i_adv, .i_dividend(r3_b_dend), .i_divisor(r3_h_dvs),
                       .o_quot(n_qb));

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_side[0] <= r3_side;
            for (int k = 1; k < DIV_QW; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // ---------------- stage 4: hue assembly and gain product ----------------
    t_side             n_sd;
    logic signed [10:0] n_hue;
    logic              r4_v;
    t_func             r4_func;
    logic [CHAN_W-1:0] r4_c1, r4_c2, r4_c3, r4_h, r4_l, r4_s;
    logic [24:0]       r4_prod;

    assign n_sd = r_side[DIV_QW-1];

    always_comb begin
        if (n_sd.rmax) begin
            n_hue = $signed(11'(n_qb)) - $signed(11'(n_qg));
        end else if (n_sd.gmax) begin
            n_hue = 11'sd0 + 11'(HUE_THIRD) + $signed(11'(n_qr)) - $signed(11'(n_qb));
        end else begin
            n_hue = 11'sd0 + 11'(HUE_NONE) + $signed(11'(n_qg)) - $signed(11'(n_qr));
        end
        if (n_hue < 0) begin
            n_hue = n_hue + 11'(HLS_SCALE);
        end else if (n_hue > 11'(HLS_SCALE)) begin
            n_hue = n_hue - 11'(HLS_SCALE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r4_func <= n_sd.func;
            r4_c1   <= n_sd.c1;
            r4_c2   <= n_sd.c2;
            r4_c3   <= n_sd.c3;
            r4_h    <= n_sd.achrom ? CHAN_W'(HUE_NONE) : CHAN_W'(n_hue);
            r4_s    <= n_sd.achrom ? '0 : n_sq;
            r4_l    <= n_sd.l;
            r4_prod <= 25'(n_sd.l) * 25'(i_gain);
        end
    end

    // ---------------- valid chain ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r_dv <= '0;
            r4_v <= 1'b0;
        end else if (i_adv) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r_dv <= {r_dv[DIV_QW-2:0], r3_v};
            r4_v <= r_dv[DIV_QW-1];
        end
    end

    // ---------------- select the request for the back end ----------------
    logic [CHAN_W-1:0] n_scaled;

    assign n_scaled = (r4_prod[24:8] > 17'(HLS_SCALE)) ? CHAN_W'(HLS_SCALE)
                                                       : r4_prod[8 +: CHAN_W];

    always_comb begin
        o_hls.func = r4_func;
        o_hls.h    = r4_h;
        o_hls.l    = r4_l;
        o_hls.s    = r4_s;
        case (r4_func)
            FN_HLS2RGB: begin
                o_hls.h = r4_c1;
                o_hls.l = r4_c2;
                o_hls.s = r4_c3;
            end
            FN_SCALE: o_hls.l = n_scaled;
            default:  ;
        endcase
    end

    assign o_valid = r4_v;

endmodule

`default_nettype wire

/* hdl/hlscc_inv.sv */
// ----------------------------------------------------------------------------
// hlscc_inv
// HLS-to-RGB back end: magic values, hue ramp per channel, byte scaling,
// final result select and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hlscc_inv
    import hlscc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_adv,
    input  wire logic              i_valid,
    input  wire t_hls              i_hls,
    output logic                   o_valid,
    output logic [CHAN_W-1:0]      o_res_first,
    output logic [CHAN_W-1:0]      o_res_second,
    output logic [CHAN_W-1:0]      o_res_third
);

    typedef enum logic [1:0] {
        SEG_RAMP = 2'd0,
        SEG_HIGH = 2'd1,
        SEG_LOW  = 2'd2
    } t_seg;

    // ---------------- stage 1: products for the magic values ----------------
    logic        r1_v;
    t_hls        r1_q;
    logic        r1_lsm;
    logic [17:0] r1_pm;
    logic [16:0] r1_pg;
    logic        n_lsm;

    assign n_lsm = i_hls.l <= CHAN_W'(HUE_HALF);

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_q   <= i_hls;
            r1_lsm <= n_lsm;
            r1_pm  <= n_lsm ? 18'(i_hls.l) * (18'(HLS_SCALE) + 18'(i_hls.s))
                            : 18'(i_hls.l) * 18'(i_hls.s);
            r1_pg  <= 17'(i_hls.l) * 17'(RGB_TOP);
        end
    end

    // ---------------- stage 2: m2 and gray level ----------------
    logic        r2_v;
    t_hls        r2_q;
    logic [9:0]  r2_m2;
    logic [7:0]  r2_gray;
    logic [9:0]  n_q;

    assign n_q = 10'(div_scale(20'(r1_pm) + 20'(HUE_HALF)));

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r2_q    <= r1_q;
            r2_m2   <= r1_lsm ? n_q : (10'(r1_q.l) + 10'(r1_q.s) - n_q);
            r2_gray <= 8'(div_scale(20'(r1_pg)));
        end
    end

    // ---------------- stage 3: hue segments and ramp products ----------------
    logic               r3_v;
    t_hls               r3_q;
    logic [7:0]         r3_gray;
    logic signed [11:0] r3_m1, r3_m2;
    logic [15:0]        r3_num [3];
    t_seg               r3_seg [3];
    logic signed [11:0] n_m1, n_dif;
    logic signed [10:0] n_hue [3];

    function automatic logic signed [10:0] wrap_hue(input logic signed [10:0] x);
        logic signed [10:0] y;
        y = x;
        if (y < 0) begin
            y = y + 11'(HLS_SCALE);
        end else if (y > 11'(HLS_SCALE)) begin
            y = y - 11'(HLS_SCALE);
        end
        return y;
    endfunction

    always_comb begin
        n_m1     = $signed(12'(r2_q.l) << 1) - $signed(12'(r2_m2));
        n_dif    = $signed(12'(r2_m2)) - n_m1;
        n_hue[0] = wrap_hue($signed(11'(r2_q.h)) + 11'(HUE_THIRD));
        n_hue[1] = $signed(11'(r2_q.h));
        n_hue[2] = wrap_hue($signed(11'(r2_q.h)) - 11'(HUE_THIRD));
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r3_q    <= r2_q;
            r3_gray <= r2_gray;
            r3_m1   <= n_m1;
            r3_m2   <= $signed(12'(r2_m2));
            for (int c = 0; c < 3; c++) begin
                if (n_hue[c] < 11'(HUE_SIXTH)) begin
                    r3_seg[c] <= SEG_RAMP;
                    r3_num[c] <= 16'(n_dif[9:0]) * 16'(n_hue[c][8:0]);
                end else if (n_hue[c] < 11'(HUE_HALF)) begin
                    r3_seg[c] <= SEG_HIGH;
                    r3_num[c] <= '0;
                end else if (n_hue[c] < 11'(HUE_NONE)) begin
                    r3_seg[c] <= SEG_RAMP;
                    r3_num[c] <= 16'(n_dif[9:0]) * 16'(9'(HUE_NONE) - n_hue[c][8:0]);
                end else begin
                    r3_seg[c] <= SEG_LOW;
                    r3_num[c] <= '0;
                end
            end
        end
    end

    // ---------------- stage 4: ramp value ----------------
    logic               r4_v;
    t_hls               r4_q;
    logic [7:0]         r4_gray;
    logic signed [11:0] r4_val [3];

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r4_q    <= r3_q;
            r4_gray <= r3_gray;
            for (int c = 0; c < 3; c++) begin
                case (r3_seg[c])
                    SEG_RAMP: r4_val[c] <= r3_m1 + $signed(12'(div_sixth(
                                   20'(r3_num[c]) + 20'(HUE_TWELFTH))));
                    SEG_HIGH: r4_val[c] <= r3_m2;
                    default:  r4_val[c] <= r3_m1;
                endcase
            end
        end
    end

    // ---------------- stage 5: byte numerator ----------------
    logic        r5_v;
    t_hls        r5_q;
    logic [7:0]  r5_gray;
    logic [19:0] r5_bnum [3];
    logic        r5_neg [3];

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r5_q    <= r4_q;
            r5_gray <= r4_gray;
            for (int c = 0; c < 3; c++) begin
                r5_neg[c]  <= r4_val[c] < 0;
                r5_bnum[c] <= 20'(r4_val[c][9:0]) * 20'(RGB_TOP) + 20'(HUE_HALF);
            end
        end
    end

    // ---------------- stage 6: byte scale, clamp, select, output ----------------
    logic [CHAN_W-1:0] n_byte [3];
    logic [CHAN_W-1:0] n_res  [3];
    logic [19:0]       n_bq   [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_bq[c] = div_scale(r5_bnum[c]);
            if (r5_neg[c]) begin
                n_byte[c] = '0;
            end else if (n_bq[c] > 20'(RGB_TOP)) begin
                n_byte[c] = CHAN_W'(RGB_TOP);
            end else begin
                n_byte[c] = n_bq[c][CHAN_W-1:0];
            end
        end
        case (r5_q.func)
            FN_RGB2HLS: begin
                n_res[0] = r5_q.h;
                n_res[1] = r5_q.l;
                n_res[2] = r5_q.s;
            end
            FN_HLS2RGB, FN_SCALE: begin
                for (int c = 0; c < 3; c++) begin
                    n_res[c] = (r5_q.s == '0) ? CHAN_W'(r5_gray) : n_byte[c];
                end
            end
            default: begin
                for (int c = 0; c < 3; c++) begin
                    n_res[c] = '0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            o_res_first  <= n_res[0];
            o_res_second <= n_res[1];
            o_res_third  <= n_res[2];
        end
    end

    // ---------------- valid chain ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r3_v    <= 1'b0;
            r4_v    <= 1'b0;
            r5_v    <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_adv) begin
            r1_v    <= i_valid;
            r2_v    <= r1_v;
            r3_v    <= r2_v;
            r4_v    <= r3_v;
            r5_v    <= r4_v;
            o_valid <= r5_v;
        end
    end

endmodule

`default_nettype wire

/* verif/rgb_hls_color_convert_tb.sv */
// ----------------------------------------------------------------------------
// rgb_hls_color_convert_tb
// Self-checking bench for the RGB/HLS color converter. Requests are predicted
// by an integer color model held here, queued, and compared channel by
// channel against each accepted result. Directed corners, gain sweeps, random
// pixels, random idling on both sides and a long output hold-off are covered.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_hls_color_convert_tb;
    import hlscc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY     = 19;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [CHAN_W-1:0] first;
        logic [CHAN_W-1:0] second;
        logic [CHAN_W-1:0] third;
    } t_pixel;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [15:0]       i_cfg_wdata = '0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [1:0]        i_func = '0;
    logic [CHAN_W-1:0] i_chan_first = '0;
    logic [CHAN_W-1:0] i_chan_second = '0;
    logic [CHAN_W-1:0] i_chan_third = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [CHAN_W-1:0] o_res_first;
    logic [CHAN_W-1:0] o_res_second;
    logic [CHAN_W-1:0] o_res_third;

    t_pixel     pixel_queue[$];
    int         gain_model = 256;
    int         mismatch_count = 0;
    int         result_count = 0;
    int         request_count = 0;
    int         cycle_count = 0;
    int         sink_idle_pct = 18;
    int         src_idle_pct = 18;
    int         hold_off_cycles = 0;

    rgb_hls_color_convert uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_func       (i_func),
        .i_chan_first (i_chan_first),
        .i_chan_second(i_chan_second),
        .i_chan_third (i_chan_third),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_res_first  (o_res_first),
        .o_res_second (o_res_second),
        .o_res_third  (o_res_third)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Color model
    // ------------------------------------------------------------------
    function automatic void model_rgb2hls(input int r, input int g, input int b,
                                          output int h, output int l, output int s);
        int hi, lo, spread, dr, dg, db, hue;
        hi = (r > g) ? r : g;
        lo = (r < g) ? r : g;
        if (b > hi) hi = b;
        if (b < lo) lo = b;
        l = ((hi + lo) * HLS_SCALE + RGB_TOP) / (2 * RGB_TOP);
        if (hi == lo) begin
            s = 0;
            h = (2 * HLS_SCALE) / 3;
            return;
        end
        spread = hi - lo;
        if (l <= HLS_SCALE / 2)
            s = (spread * HLS_SCALE + (hi + lo) / 2) / (hi + lo);
        else
            s = (spread * HLS_SCALE + (2 * RGB_TOP - hi - lo) / 2) / (2 * RGB_TOP - hi - lo);
        dr = ((hi - r) * (HLS_SCALE / 6) + spread / 2) / spread;
        dg = ((hi - g) * (HLS_SCALE / 6) + spread / 2) / spread;
        db = ((hi - b) * (HLS_SCALE / 6) + spread / 2) / spread;
        if (r == hi) hue = db - dg;
        else if (g == hi) hue = HLS_SCALE / 3 + dr - db;
        else hue = (2 * HLS_SCALE) / 3 + dg - dr;
        if (hue < 0) hue += HLS_SCALE;
        if (hue > HLS_SCALE) hue -= HLS_SCALE;
        h = hue;
    endfunction

    function automatic int ramp_level(input int n1, input int n2, input int hue);
        if (hue < 0) hue += HLS_SCALE;
        if (hue > HLS_SCALE) hue -= HLS_SCALE;
        if (hue < HLS_SCALE / 6)
            return n1 + ((n2 - n1) * hue + HLS_SCALE / 12) / (HLS_SCALE / 6);
        if (hue < HLS_SCALE / 2)
            return n2;
        if (hue < (HLS_SCALE * 2) / 3)
            return n1 + ((n2 - n1) * ((HLS_SCALE * 2) / 3 - hue) + HLS_SCALE / 12)
                        / (HLS_SCALE / 6);
        return n1;
    endfunction

    function automatic int level_to_byte(input int v);
        int c;
        c = (v * RGB_TOP + HLS_SCALE / 2) / HLS_SCALE;
        if (c < 0) c = 0;
        if (c > RGB_TOP) c = RGB_TOP;
        return c;
    endfunction

    function automatic void model_hls2rgb(input int h, input int l, input int s,
                                          output int r, output int g, output int b);
        int m1, m2;
        if (s == 0) begin
            r = (l * RGB_TOP) / HLS_SCALE;
            g = r;
            b = r;
            return;
        end
        if (l <= HLS_SCALE / 2)
            m2 = (l * (HLS_SCALE + s) + HLS_SCALE / 2) / HLS_SCALE;
        else
            m2 = l + s - (l * s + HLS_SCALE / 2) / HLS_SCALE;
        m1 = 2 * l - m2;
        r = level_to_byte(ramp_level(m1, m2, h + HLS_SCALE / 3));
        g = level_to_byte(ramp_level(m1, m2, h));
        b = level_to_byte(ramp_level(m1, m2, h - HLS_SCALE / 3));
    endfunction

    function automatic t_pixel convert_pixel(input t_func fn, input int c1, input int c2,
                                             input int c3);
        int a, b, c, h, l, s;
        longint scaled;
        t_pixel px;
        a = 0; b = 0; c = 0;
        if (fn == FN_RGB2HLS || fn == FN_SCALE) begin
            model_rgb2hls((c1 > RGB_TOP) ? RGB_TOP : c1, (c2 > RGB_TOP) ? RGB_TOP : c2,
                          (c3 > RGB_TOP) ? RGB_TOP : c3, h, l, s);
            if (fn == FN_RGB2HLS) begin
                a = h; b = l; c = s;
            end else begin
                scaled = (longint'(l) * gain_model) >>> 8;
                if (scaled > HLS_SCALE) scaled = HLS_SCALE;
                model_hls2rgb(h, int'(scaled), s, a, b, c);
            end
        end else if (fn == FN_HLS2RGB) begin
            model_hls2rgb((c1 > HLS_SCALE) ? HLS_SCALE : c1,
                          (c2 > HLS_SCALE) ? HLS_SCALE : c2,
                          (c3 > HLS_SCALE) ? HLS_SCALE : c3, a, b, c);
        end
        px.first = a[CHAN_W-1:0];
        px.second = b[CHAN_W-1:0];
        px.third = c[CHAN_W-1:0];
        return px;
    endfunction

    // ------------------------------------------------------------------
    // Cycle counter and timeout
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     pixel_queue.size());
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Result side: random stall, long hold-off, check against oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_pixel want;
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < sink_idle_pct);
        end
        if (i_rst_n && o_valid && !i_stall) begin
            result_count <= result_count + 1;
            if (pixel_queue.size() == 0) begin
                mismatch_count <= mismatch_count + 1;
                if (mismatch_count < 10)
                    $display("unexpected result %0d %0d %0d", o_res_first, o_res_second,
                             o_res_third);
            end else begin
                want = pixel_queue.pop_front();
                if (want !== {o_res_first, o_res_second, o_res_third}) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10)
                        $display("mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                                 want.first, want.second, want.third,
                                 o_res_first, o_res_second, o_res_third);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    task automatic send_pixel(input t_func fn, input int c1, input int c2, input int c3);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= fn;
        i_chan_first <= c1[CHAN_W-1:0];
        i_chan_second <= c2[CHAN_W-1:0];
        i_chan_third <= c3[CHAN_W-1:0];
        pixel_queue.push_back(convert_pixel(fn, c1, c2, c3));
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        request_count++;
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pixel_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_gain(input int gain);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= gain[15:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        gain_model = gain;
    endtask

    task automatic send_random(input int n);
        int k, fn, pick;
        for (k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            fn = (pick < 30) ? FN_RGB2HLS : (pick < 60) ? FN_HLS2RGB :
                 (pick < 95) ? FN_SCALE : FN_NONE;
            if ($urandom_range(9) == 0)
                send_pixel(t_func'(fn), $urandom_range(511), $urandom_range(511),
                           $urandom_range(511));
            else if (fn == FN_HLS2RGB)
                send_pixel(t_func'(fn), $urandom_range(360), $urandom_range(360),
                           ($urandom_range(7) == 0) ? 0 : $urandom_range(360));
            else
                send_pixel(t_func'(fn), $urandom_range(255), $urandom_range(255),
                           $urandom_range(255));
        end
    endtask

    // Corners: extremes, achromatic, over-range saturation, zero saturation, hue wrap
    task automatic test_directed();
        send_pixel(FN_RGB2HLS, 0, 0, 0);
        send_pixel(FN_RGB2HLS, 255, 255, 255);
        send_pixel(FN_RGB2HLS, 511, 300, 256);
        send_pixel(FN_RGB2HLS, 255, 0, 0);
        send_pixel(FN_RGB2HLS, 255, 0, 1);
        send_pixel(FN_RGB2HLS, 0, 255, 0);
        send_pixel(FN_RGB2HLS, 0, 0, 255);
        send_pixel(FN_RGB2HLS, 200, 100, 50);
        send_pixel(FN_HLS2RGB, 0, 180, 360);
        send_pixel(FN_HLS2RGB, 360, 360, 360);
        send_pixel(FN_HLS2RGB, 511, 511, 511);
        send_pixel(FN_HLS2RGB, 100, 200, 0);
        send_pixel(FN_HLS2RGB, 359, 90, 300);
        send_pixel(FN_HLS2RGB, 1, 270, 10);
        send_pixel(FN_HLS2RGB, 240, 0, 180);
        send_pixel(FN_SCALE, 200, 100, 50);
        send_pixel(FN_SCALE, 511, 511, 0);
        send_pixel(FN_SCALE, 10, 10, 10);
        send_pixel(FN_NONE, 511, 511, 511);
        send_pixel(FN_NONE, 0, 0, 0);
        drain_results();
    endtask

    // Sweep the gain through its extremes and some mid values
    task automatic test_gain_sweep();
        int gains[6] = '{0, 65535, 128, 512, 1, 300};
        foreach (gains[i]) begin
            write_gain(gains[i]);
            send_pixel(FN_SCALE, 200, 100, 50);
            send_pixel(FN_SCALE, 255, 255, 255);
            send_random(60);
            drain_results();
        end
        write_gain(256);
    endtask

    // Hold the output off while requests keep coming, so the pipe back-pressures
    task automatic test_back_pressure();
        hold_off_cycles = 80;
        send_random(60);
        drain_results();
    endtask

    // Random traffic with and without idling
    task automatic test_random_traffic();
        send_random(300);
        sink_idle_pct = 0;
        src_idle_pct = 0;
        send_random(200);
        sink_idle_pct = 18;
        src_idle_pct = 18;
        // Empty the pipe before touching the gain
        drain_results();
        write_gain($urandom_range(65535));
        send_random(60);
        drain_results();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_gain_sweep();
        test_back_pressure();
        test_random_traffic();
        $display("covered %0d requests / %0d results over all functions, gain extremes,",
                 request_count, result_count);
        $display("over-range channels, random idling and a long output hold-off");
        if (mismatch_count == 0 && pixel_queue.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatch_count,
                     pixel_queue.size());
            $display("FAILURE");
        end
        $finish;
    end
endmodule

`default_nettype wire

/* filelist.f */
hdl/hlscc_pkg.sv
hdl/hlscc_div.sv
hdl/hlscc_fwd.sv
hdl/hlscc_inv.sv
hdl/rgb_hls_color_convert.sv
verif/rgb_hls_color_convert_tb.sv
